@@ hdl/hpqd_pkg.sv @@
package hpqd_pkg;

  localparam int NUM_PAT = 5;
  localparam int ST1_W   = 31;
  localparam int ST34_W  = 15;
  localparam int FOLD_W  = 3;
  localparam int QUAL_W  = 6;
  localparam int HIST_W  = 3;
  localparam int ROW_W   = NUM_PAT * HIST_W;

  // result buffer depth and the width of its occupancy count
  localparam int OFIFO_DEPTH = 3;
  localparam int OFIFO_CW    = 2;
  localparam int OFIFO_PW    = 2;

  typedef logic [HIST_W-1:0]          hist_t;
  typedef hist_t [NUM_PAT-1:0]        row_t;
  typedef logic [QUAL_W-1:0]          qual_t;
  typedef logic [FOLD_W-1:0]          fold_t;

  // station 1 bit windows per pattern
  localparam logic [ST1_W-1:0] ST1_WIN [NUM_PAT] = '{
    31'h7F8000FF, 31'h00780F00, 31'h00063000, 31'h00014000, 31'h00008000
  };

  // station 3 and 4 bit windows per pattern
  localparam logic [ST34_W-1:0] ST34_WIN [NUM_PAT] = '{
    15'h7FFF, 15'h7FFF, 15'h07F0, 15'h01C0, 15'h0080
  };

  // layer bit positions within a mask
  localparam int LY_ST1  = 2;
  localparam int LY_ST2  = 1;
  localparam int LY_ST34 = 0;

endpackage

@@ hdl/hpqd_if.sv @@
interface hpqd_in_if
  import hpqd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ST1_W-1:0]   hits_station_one;
  logic               hit_station_two;
  logic [ST34_W-1:0]  hits_station_three;
  logic [ST34_W-1:0]  hits_station_four;
  logic [FOLD_W-1:0]  fold_index;

  modport source (
    output valid, hits_station_one, hit_station_two, hits_station_three,
           hits_station_four, fold_index,
    input  ready
  );
  modport sink (
    input  valid, hits_station_one, hit_station_two, hits_station_three,
           hits_station_four, fold_index,
    output ready
  );
endinterface

interface hpqd_out_if
  import hpqd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [QUAL_W-1:0] best_quality;

  modport source (output valid, best_quality, input ready);
  modport sink   (input valid, best_quality, output ready);
endinterface

@@ hdl/hit_pattern_quality_detector.sv @@
// a result can be taken once its item has passed the stage 1 registers into the result buffer
// throughput: one item per cycle while the result buffer has room, set by the
//   read-modify-write of the history memory (one read port, one write port)
// the three-entry result buffer lets input flow on while results wait
// reset (synchronous, rst_n low) clears the pipeline, the result buffer and
//   the per-fold valid bits, so every history reads as zero right after reset
module hit_pattern_quality_detector
  import hpqd_pkg::*;
#(
  parameter int FOLDS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  hpqd_in_if.sink    in_ch,
  hpqd_out_if.source out_ch
);

  localparam int AW = (FOLDS > 1) ? $clog2(FOLDS) : 1;

  // input side
  logic               accept;
  logic               in_range;
  row_t               layers;
  logic [OFIFO_CW-1:0] fifo_count;
  logic [OFIFO_CW:0]   in_flight;

  // stage 1: history row arrives from memory
  logic               s1_vld_r;
  logic               s1_in_range_r;
  logic [AW-1:0]      s1_fold_r;
  row_t               s1_layers_r;

  // last write, for forwarding to the item right behind it
  logic               wr_vld_r;
  logic [AW-1:0]      wr_fold_r;
  row_t               wr_row_r;

  logic [FOLDS-1:0]   fold_vld_r, fold_vld_nxt;

  logic [ROW_W-1:0]   ram_rdata;
  row_t               hist_row;
  row_t               hist_new;
  qual_t              best;
  qual_t              result;
  logic               wr_en;

  // items in stage 1 plus results held must leave room in the buffer
  assign in_flight   = {1'b0, fifo_count} + (OFIFO_CW+1)'(s1_vld_r);
  assign in_ch.ready = (in_flight < (OFIFO_CW+1)'(OFIFO_DEPTH));
  assign accept      = in_ch.valid & in_ch.ready;
  assign in_range    = (32'(in_ch.fold_index) < FOLDS);

  // layer masks for every pattern, straight from the hit vectors
  hpqd_layers u_layers (
    .hits_one   (in_ch.hits_station_one),
    .hit_two    (in_ch.hit_station_two),
    .hits_three (in_ch.hits_station_three),
    .hits_four  (in_ch.hits_station_four),
    .layers     (layers)
  );

  // one row per fold, holding the history of all five patterns
  hpqd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (FOLDS),
    .AW    (AW)
  ) u_hist_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_fold_r),
    .wdata (hist_new),
    .re    (accept & in_range),
    .raddr (in_ch.fold_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      wr_vld_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range_r <= in_range;
      s1_fold_r     <= in_ch.fold_index[AW-1:0];
      s1_layers_r   <= layers;
    end
    wr_fold_r <= s1_fold_r;
    wr_row_r  <= hist_new;
  end

  // the memory read ran alongside the previous write, so that write is forwarded
  // when it went to the same fold; a never-written fold reads as zero
  always_comb begin
    if (wr_vld_r && (wr_fold_r == s1_fold_r)) begin
      hist_row = wr_row_r;
    end else if (fold_vld_r[s1_fold_r]) begin
      hist_row = row_t'(ram_rdata);
    end else begin
      hist_row = '0;
    end
  end

  hpqd_score u_score (
    .layers   (s1_layers_r),
    .hist     (hist_row),
    .hist_nxt (hist_new),
    .best     (best)
  );

  assign wr_en  = s1_vld_r & s1_in_range_r;
  // an out-of-range fold touches no history and scores zero
  assign result = s1_in_range_r ? best : '0;

  always_comb begin
    fold_vld_nxt = fold_vld_r;
    if (wr_en) begin
      fold_vld_nxt[s1_fold_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_vld_r <= '0;
    end else begin
      fold_vld_r <= fold_vld_nxt;
    end
  end

  hpqd_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_vld_r),
    .push_data (result),
    .count     (fifo_count),
    .out_ch    (out_ch)
  );

endmodule

@@ hdl/hpqd_ram.sv @@
module hpqd_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/hpqd_layers.sv @@
module hpqd_layers
  import hpqd_pkg::*;
(
  input  logic [ST1_W-1:0]  hits_one,
  input  logic              hit_two,
  input  logic [ST34_W-1:0] hits_three,
  input  logic [ST34_W-1:0] hits_four,
  output row_t              layers
);

  logic [ST34_W-1:0] hits_34;

  assign hits_34 = hits_three | hits_four;

  always_comb begin
    for (int p = 0; p < NUM_PAT; p++) begin
      layers[p][LY_ST1]  = |(hits_one & ST1_WIN[p]);
      layers[p][LY_ST2]  = hit_two;
      layers[p][LY_ST34] = |(hits_34 & ST34_WIN[p]);
    end
  end

endmodule

@@ hdl/hpqd_score.sv @@
module hpqd_score
  import hpqd_pkg::*;
(
  input  row_t  layers,
  input  row_t  hist,
  output row_t  hist_nxt,
  output qual_t best
);

  qual_t q [NUM_PAT];

  always_comb begin
    logic [2:0] st;
    logic       two;
    hist_t      ly;
    hist_t      h;
    for (int p = 0; p < NUM_PAT; p++) begin
      st  = 3'(p);
      ly  = layers[p];
      h   = hist[p];
      two = (ly[2] & ly[1]) | (ly[2] & ly[0]) | (ly[1] & ly[0]);
      // hit two steps back, none three steps back, two or more layers now
      if (!h[2] && h[1] && two) begin
        q[p] = {st[2], ly[2], st[1], ly[1], st[0], ly[0]};
      end else begin
        q[p] = '0;
      end
      hist_nxt[p] = {h[1:0], |ly};
    end
  end

  always_comb begin
    best = '0;
    for (int p = 0; p < NUM_PAT; p++) begin
      if (q[p] > best) begin
        best = q[p];
      end
    end
  end

endmodule

@@ hdl/hpqd_ofifo.sv @@
module hpqd_ofifo
  import hpqd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qual_t               push_data,
  output logic [OFIFO_CW-1:0] count,
  hpqd_out_if.source          out_ch
);

  qual_t               buf_r [OFIFO_DEPTH];
  logic [OFIFO_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OFIFO_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OFIFO_CW-1:0] count_r, count_nxt;
  logic                pop;

  assign pop = out_ch.valid & out_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == OFIFO_PW'(OFIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == OFIFO_PW'(OFIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign count               = count_r;
  assign out_ch.valid        = (count_r != '0);
  assign out_ch.best_quality = buf_r[rd_ptr_r];

endmodule

@@ tb/tb_hit_pattern_quality_detector.sv @@
`timescale 1ns / 1ps

module tb_hit_pattern_quality_detector;
  import hpqd_pkg::*;

  // history slots in the block under test, the full range of the fold field
  localparam int TB_FOLDS       = 8;
  // cycles with no item moving on either channel before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  // quiet cycles after the last result, well past the latency of the block
  localparam int TAIL_CYCLES    = 16;

  // station windows per pattern, kept apart from the package so that a wrong
  // constant in the design shows up as a mismatch
  localparam logic [ST1_W-1:0] HIT1_WINDOW [NUM_PAT] = '{
    31'h7F8000FF, 31'h00780F00, 31'h00063000, 31'h00014000, 31'h00008000
  };
  localparam logic [ST34_W-1:0] HIT34_WINDOW [NUM_PAT] = '{
    15'h7FFF, 15'h7FFF, 15'h07F0, 15'h01C0, 15'h0080
  };

  // content of one step of a track on a fold
  typedef enum int {
    STEP_MISS,
    STEP_HIT,
    STEP_SPARSE,
    STEP_STRONG
  } step_kind_e;

  logic clk = 1'b0;
  logic rst_n;

  hpqd_in_if  in_ch ();
  hpqd_out_if out_ch ();

  hit_pattern_quality_detector #(
    .FOLDS(TB_FOLDS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // predictor state: 3-deep any-layer-hit history per pattern and fold, bit 0 newest
  logic [HIST_W-1:0] fold_hist [NUM_PAT][TB_FOLDS];

  // predicted best quality of each accepted item, oldest first
  qual_t quality_queue [$];

  int  err_count    = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  int  stall_left   = 0;
  // random idling on both channels, switched off for the last part
  bit  idle_en      = 1'b1;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // best quality over all patterns for one item; advances the fold history
  function automatic qual_t predict_quality(input logic [ST1_W-1:0] s1, input logic s2,
                                            input logic [ST34_W-1:0] s3,
                                            input logic [ST34_W-1:0] s4, input fold_t fold);
    logic [2:0]        ly;
    logic [2:0]        st;
    logic [HIST_W-1:0] h;
    logic              two;
    qual_t             q;
    qual_t             best;
    best = '0;
    // a fold past the history depth touches nothing and scores zero
    if (int'(fold) >= TB_FOLDS) return '0;
    for (int p = 0; p < NUM_PAT; p++) begin
      ly[2] = |(s1 & HIT1_WINDOW[p]);
      ly[1] = s2;
      ly[0] = |((s3 | s4) & HIT34_WINDOW[p]);
      two   = $countones(ly) >= 2;
      st    = 3'(p);
      h     = fold_hist[p][fold];
      q     = '0;
      // hit two steps back, none three steps back, two or more layers now
      if (!h[2] && h[1] && two)
        q = {st[2], ly[2], st[1], ly[1], st[0], ly[0]};
      if (q > best) best = q;
      fold_hist[p][fold] = {h[1:0], |ly};
    end
    return best;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int lowest_bit(input logic [ST1_W-1:0] mask);
    for (int i = 0; i < ST1_W; i++)
      if (mask[i]) return i;
    return 0;
  endfunction

  // a few scattered hits so that single patterns light up, not all of them
  function automatic logic [ST1_W-1:0] sparse_hits(input int width, input int min_bits);
    logic [ST1_W-1:0] v;
    v = '0;
    repeat ($urandom_range(min_bits, 2)) v[$urandom_range(0, width - 1)] = 1'b1;
    return v;
  endfunction

  // drive one item, wait for the handshake, then record its prediction
  task automatic send_hits(input logic [ST1_W-1:0] s1, input logic s2,
                           input logic [ST34_W-1:0] s3, input logic [ST34_W-1:0] s4,
                           input fold_t fold);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.hits_station_one   <= s1;
    in_ch.hit_station_two    <= s2;
    in_ch.hits_station_three <= s3;
    in_ch.hits_station_four  <= s4;
    in_ch.fold_index         <= fold;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    quality_queue.push_back(predict_quality(s1, s2, s3, s4, fold));
    items_sent++;
  endtask

  // random item, fully random or sparse, covers every input bit at both values
  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_hits(ST1_W'($urandom), 1'($urandom), ST34_W'($urandom), ST34_W'($urandom),
                fold_t'($urandom_range(0, TB_FOLDS - 1)));
    else
      send_hits(sparse_hits(ST1_W, 0), 1'($urandom_range(0, 3) == 0),
                ST34_W'(sparse_hits(ST34_W, 0)), ST34_W'(sparse_hits(ST34_W, 0)),
                fold_t'($urandom_range(0, TB_FOLDS - 1)));
  endtask

  task automatic send_step(input fold_t fold, input step_kind_e kind);
    logic [ST1_W-1:0]  s1;
    logic              s2;
    logic [ST34_W-1:0] s3;
    logic [ST34_W-1:0] s4;
    s1 = '0;
    s2 = 1'b0;
    s3 = '0;
    s4 = '0;
    case (kind)
      STEP_MISS: begin
      end
      STEP_HIT: begin
        case ($urandom_range(0, 2))
          0:       s1 = sparse_hits(ST1_W, 1);
          1:       s2 = 1'b1;
          default: s3 = ST34_W'(sparse_hits(ST34_W, 1));
        endcase
      end
      STEP_SPARSE: begin
        s1 = sparse_hits(ST1_W, 0);
        s2 = $urandom_range(0, 3) == 0;
        s3 = ST34_W'(sparse_hits(ST34_W, 0));
        s4 = ST34_W'(sparse_hits(ST34_W, 0));
      end
      STEP_STRONG: begin
        if ($urandom_range(0, 3) != 0) s1 = sparse_hits(ST1_W, 1);
        s2 = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1) == 0) s3 = ST34_W'(sparse_hits(ST34_W, 1));
          else                           s4 = ST34_W'(sparse_hits(ST34_W, 1));
        end
      end
      default: begin
      end
    endcase
    send_hits(s1, s2, s3, s4, fold);
  endtask

  // mostly the miss, hit, any, strong order that lets a pattern score,
  // otherwise shuffled steps or plain noise
  task automatic send_track();
    fold_t fold;
    int    kind;
    fold = fold_t'($urandom_range(0, TB_FOLDS - 1));
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      for (int s = 0; s < 4; s++) begin
        // noise items on random folds may cut in between steps
        if ($urandom_range(0, 4) == 0) send_noise();
        case (s)
          0:       send_step(fold, STEP_MISS);
          1:       send_step(fold, STEP_HIT);
          2:       send_step(fold, $urandom_range(0, 1) ? STEP_SPARSE : STEP_MISS);
          default: send_step(fold, STEP_STRONG);
        endcase
      end
    end else if (kind == 7) begin
      for (int s = 0; s < 4; s++)
        send_step(fold, step_kind_e'($urandom_range(0, 3)));
    end else begin
      send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, then each pattern scoring alone on its own fold
  task automatic test_directed_patterns();
    logic [ST1_W-1:0]  v1;
    logic [ST34_W-1:0] v34;
    send_hits('0, 1'b0, '0, '0, fold_t'(0));
    // all ones: the third one scores every pattern, the fourth sees a hit
    // three steps back and scores nothing
    repeat (4) send_hits('1, 1'b1, '1, '1, fold_t'(TB_FOLDS - 1));
    for (int p = 0; p < NUM_PAT; p++) begin
      v1  = '0;
      v34 = '0;
      v1[lowest_bit(HIT1_WINDOW[p])]          = 1'b1;
      v34[lowest_bit(ST1_W'(HIT34_WINDOW[p]))] = 1'b1;
      send_hits('0, 1'b0, '0, '0, fold_t'(p));
      send_hits(v1, 1'b0, '0, '0, fold_t'(p));
      send_hits('0, 1'b0, '0, '0, fold_t'(p));
      // all three layers on even patterns, station 1 with station 4 on odd
      if (p % 2 == 0) send_hits(v1, 1'b1, v34, '0, fold_t'(p));
      else            send_hits(v1, 1'b0, '0, v34, fold_t'(p));
    end
  endtask

  task automatic test_random_tracks(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_track();
  endtask

  // sender holds off until the result buffer has fully drained
  task automatic test_drain_pause();
    repeat (3) send_track();
    in_ch.valid <= 1'b0;
    while (quality_queue.size() != 0) @(posedge clk);
    repeat (3) send_track();
  endtask

  // no idling on either side, items every cycle the block allows
  task automatic test_back_to_back(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_track();
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input qual_t got, input qual_t want);
    $display("mismatch on result %0d: %s, got %0d, want %0d", results_seen, what, got, want);
    err_count++;
  endtask

  // receiver stalls in bursts, and ready is high again between any two bursts
  always @(posedge clk) begin
    if (!idle_en) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (out_ch.ready && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    qual_t want_q;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (quality_queue.size() == 0) begin
        report_mismatch("result with no item pending", out_ch.best_quality, '0);
      end else begin
        want_q = quality_queue.pop_front();
        if (out_ch.best_quality !== want_q)
          report_mismatch("best_quality", out_ch.best_quality, want_q);
      end
      results_seen++;
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.hits_station_one   = '0;
    in_ch.hit_station_two    = 1'b0;
    in_ch.hits_station_three = '0;
    in_ch.hits_station_four  = '0;
    in_ch.fold_index         = '0;
    out_ch.ready             = 1'b0;
    foreach (fold_hist[p, f]) fold_hist[p][f] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_patterns();
    test_random_tracks(240);
    test_drain_pause();
    test_random_tracks(200);
    idle_en = 1'b0;
    test_back_to_back(80);

    // let every pending result arrive, then watch for strays
    in_ch.valid <= 1'b0;
    while (quality_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hpqd_pkg.sv
hdl/hpqd_if.sv
hdl/hpqd_ram.sv
hdl/hpqd_layers.sv
hdl/hpqd_score.sv
hdl/hpqd_ofifo.sv
hdl/hit_pattern_quality_detector.sv
tb/tb_hit_pattern_quality_detector.sv
